>>> hdl/rrm_pkg.sv
// Shared definitions for the ramped resampling mixer: field widths, command
// and mode codes, register indexes and the structs passed between modules.
// No dependencies.
package rrm_pkg;

    localparam int POS_W       = 44;
    localparam int VOL_W       = 32;
    localparam int ACC_W       = 32;
    localparam int SAMPLE_W    = 8;
    localparam int ADDR_IN_W   = 12;
    localparam int CMD_W       = 2;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 44;
    localparam int S_TDATA_W   = 88;
    localparam int M_TDATA_W   = 64;
    localparam int FRAC_TOP    = 32;

    localparam int DEFAULT_STORE_DEPTH = 4096;
    localparam int DEFAULT_FRAC_SHIFT  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MIX     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MONO     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEREO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SURROUND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_INCREMENT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_VOLUME_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_VOLUME_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_RAMP          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_RAMP         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE        = 3'd7;

    localparam logic [POS_W-1:0] STEP_RESET = 44'h001_0000_0000;

    typedef struct packed {
        logic [POS_W-1:0]  step_increment;
        logic [POS_W-1:0]  start_position;
        logic [VOL_W-1:0]  left_volume_start;
        logic [VOL_W-1:0]  right_volume_start;
        logic [VOL_W-1:0]  left_ramp;
        logic [VOL_W-1:0]  right_ramp;
        logic [MODE_W-1:0] channel_mode;
        logic              interpolate;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]     kind;
        logic [ADDR_IN_W-1:0] sample_addr;
        logic [SAMPLE_W-1:0]  sample_value;
        logic [ACC_W-1:0]     dest_left;
        logic [ACC_W-1:0]     dest_right;
    } entry_t;

endpackage

>>> hdl/rrm_front.sv
// Input stage: accepts stream transactions, drops unused commands and
// packs the rest into queue entries. Depends on rrm_pkg.
module rrm_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rrm_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rrm_pkg::CMD_W-1:0]     s_tuser,
    output logic                          push_valid,
    input  logic                          push_ready,
    output rrm_pkg::entry_t               push_data
);

    logic            ent_valid_reg;
    logic            ent_valid_next;
    rrm_pkg::entry_t ent_reg;
    logic            keep;
    logic            accept;

    assign s_tready   = !ent_valid_reg || push_ready;
    assign accept     = s_tvalid && s_tready;
    assign push_valid = ent_valid_reg;
    assign push_data  = ent_reg;

    always_comb
    begin
        unique case (s_tuser) inside
            rrm_pkg::CMD_WRITE, rrm_pkg::CMD_MIX, rrm_pkg::CMD_RESTART: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (ent_valid_reg && push_ready)
        begin
            ent_valid_next = 1'b0;
        end
        if (accept)
        begin
            ent_valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg.kind         <= s_tuser;
            ent_reg.sample_addr  <= s_tdata[11:0];
            ent_reg.sample_value <= s_tdata[19:12];
            ent_reg.dest_left    <= s_tdata[51:20];
            ent_reg.dest_right   <= s_tdata[83:52];
        end
    end

endmodule

>>> hdl/rrm_queue.sv
// Short FIFO of decoded commands between the input stage and the mixing
// sequencer. Depends on rrm_pkg.
module rrm_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  rrm_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rrm_pkg::entry_t pop_data
);

    rrm_pkg::entry_t                entries [rrm_pkg::QUEUE_DEPTH];
    logic [rrm_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rrm_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rrm_pkg::QCNT_W-1:0]     count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = count_reg != rrm_pkg::QCNT_W'(rrm_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= rrm_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rrm_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= rrm_pkg::QCNT_W'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= rrm_pkg::QCNT_W'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/rrm_back.sv
// Mixing sequencer: sample store, read position, volumes, address wrap,
// interpolation, scaling and the output register. Depends on rrm_pkg.
module rrm_back
#(
    parameter int STORE_DEPTH = rrm_pkg::DEFAULT_STORE_DEPTH,
    parameter int FRAC_SHIFT  = rrm_pkg::DEFAULT_FRAC_SHIFT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrm_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  rrm_pkg::entry_t               q_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rrm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int XW          = rrm_pkg::ADDR_IN_W;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 25;
    localparam longint unsigned RECIP_VAL =
        ((64'd1 << RECIP_SHIFT) + STORE_DEPTH - 1) / STORE_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_VAL[RECIP_W-1:0];
    localparam longint unsigned    DEPTH_MOD = STORE_DEPTH % (1 << XW);
    localparam logic [XW-1:0]      DEPTH_LO  = DEPTH_MOD[XW-1:0];
    localparam logic [AW-1:0]      LAST_ADDR = AW'(STORE_DEPTH - 1);
    localparam int PROD_W = rrm_pkg::SAMPLE_W + 1 + FRAC_SHIFT + 1;
    localparam int SW     = rrm_pkg::SAMPLE_W;
    localparam int ACW    = rrm_pkg::ACC_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WRAP   = 3'd1;
    localparam logic [2:0] S_INTERP = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [rrm_pkg::POS_W-1:0]   pos_reg;
    logic [rrm_pkg::POS_W-1:0]   pos_next;
    logic [rrm_pkg::VOL_W-1:0]   lvol_reg;
    logic [rrm_pkg::VOL_W-1:0]   lvol_next;
    logic [rrm_pkg::VOL_W-1:0]   rvol_reg;
    logic [rrm_pkg::VOL_W-1:0]   rvol_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        load_out;

    logic [SW-1:0]               store [STORE_DEPTH];

    logic [rrm_pkg::CMD_W-1:0]   kind_reg;
    logic [SW-1:0]               wval_reg;
    logic [ACW-1:0]              dl_reg;
    logic [ACW-1:0]              dr_reg;
    logic [XW-1:0]               x_in;
    logic [XW+RECIP_W-1:0]       recip_prod;
    logic [XW-1:0]               x_reg;
    logic [XW-1:0]               quot_reg;
    logic [2*XW-1:0]             back_prod;
    logic [XW-1:0]               rem;
    logic [AW-1:0]               a0;
    logic [AW-1:0]               a1;
    logic signed [SW-1:0]        rd0_reg;
    logic signed [SW-1:0]        rd1_reg;
    logic signed [SW:0]          diff;
    logic [FRAC_SHIFT-1:0]       weight;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [PROD_W-1:0]    prod_shift;
    logic [SW-1:0]               lerp;
    logic [SW-1:0]               smp;
    logic [ACW-1:0]              smp_ext;
    logic [ACW-1:0]              pl_reg;
    logic [ACW-1:0]              pr_reg;
    logic [ACW-1:0]              mixed_left;
    logic [ACW-1:0]              mixed_right;
    logic [rrm_pkg::M_TDATA_W-1:0] out_data_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Integer part of the position or the write address, reduced modulo the
    // store depth by a reciprocal multiply and a back multiply.
    assign x_in       = (q_data.kind == rrm_pkg::CMD_MIX) ?
                        pos_reg[rrm_pkg::FRAC_TOP +: XW] : q_data.sample_addr;
    assign recip_prod = x_in * RECIP;
    assign back_prod  = quot_reg * DEPTH_LO;
    assign rem        = x_reg - back_prod[XW-1:0];
    assign a0         = AW'(rem);
    assign a1         = (a0 == LAST_ADDR) ? '0 : AW'(a0 + 1'b1);

    assign weight     = pos_reg[rrm_pkg::FRAC_TOP-1 -: FRAC_SHIFT];
    assign diff       = {rd1_reg[SW-1], rd1_reg} - {rd0_reg[SW-1], rd0_reg};
    assign prod_next  = diff * $signed({1'b0, weight});
    assign prod_shift = prod_reg >>> FRAC_SHIFT;
    assign lerp       = rd0_reg + prod_shift[SW-1:0];
    assign smp        = cfg.interpolate ? lerp : rd0_reg;
    assign smp_ext    = {{(ACW-SW){smp[SW-1]}}, smp};

    assign mixed_left = dl_reg + pl_reg;

    always_comb
    begin
        case (cfg.channel_mode)
            rrm_pkg::MODE_MONO:   mixed_right = dr_reg;
            rrm_pkg::MODE_STEREO: mixed_right = dr_reg + pr_reg;
            default:              mixed_right = dr_reg - pl_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        lvol_next      = lvol_reg;
        rvol_next      = rvol_reg;
        out_valid_next = out_valid_reg;
        q_ready        = 1'b0;
        load_out       = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    unique case (q_data.kind)
                        rrm_pkg::CMD_RESTART:
                        begin
                            pos_next  = cfg.start_position;
                            lvol_next = cfg.left_volume_start;
                            rvol_next = cfg.right_volume_start;
                        end
                        rrm_pkg::CMD_MIX:
                        begin
                            lvol_next = lvol_reg + cfg.left_ramp;
                            if (cfg.channel_mode == rrm_pkg::MODE_STEREO)
                            begin
                                rvol_next = rvol_reg + cfg.right_ramp;
                            end
                            state_next = S_WRAP;
                        end
                        rrm_pkg::CMD_WRITE:
                        begin
                            state_next = S_WRAP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRAP:
            begin
                state_next = (kind_reg == rrm_pkg::CMD_MIX) ? S_INTERP : S_IDLE;
            end
            S_INTERP:
            begin
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + cfg.step_increment;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            lvol_reg      <= '0;
            rvol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            lvol_reg      <= lvol_next;
            rvol_reg      <= rvol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid)
        begin
            kind_reg <= q_data.kind;
            wval_reg <= q_data.sample_value;
            dl_reg   <= q_data.dest_left;
            dr_reg   <= q_data.dest_right;
            x_reg    <= x_in;
            quot_reg <= recip_prod[RECIP_SHIFT +: XW];
        end
        if (state_reg == S_INTERP)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == S_SCALE)
        begin
            pl_reg <= lvol_reg * smp_ext;
            pr_reg <= rvol_reg * smp_ext;
        end
        if (load_out)
        begin
            out_data_reg <= {mixed_right, mixed_left};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRAP)
        begin
            if (kind_reg == rrm_pkg::CMD_WRITE)
            begin
                store[a0] <= wval_reg;
            end
            else
            begin
                rd0_reg <= store[a0];
                rd1_reg <= store[a1];
            end
        end
    end

endmodule

>>> hdl/ramped_resampling_mixer_unit.sv
// Top level of the ramped resampling mixer: configuration registers and the
// input stage, command queue and mixing sequencer. Depends on rrm_pkg,
// rrm_front, rrm_queue and rrm_back.
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   s_tdata, s_tuser (command)
//   m_*       out        m_tvalid/m_tready   m_tdata (mixed frame)
//   cfg_*     in         cfg_we              cfg_index, cfg_wdata
//
// A mix command occupies the sequencer for address wrap and store read,
// interpolation multiply, volume multiply and output load; only then is the
// next command taken. A sample write ends after the address wrap, a restart
// in the idle state; the input stage and a four-entry queue register commands.
// Reset clears the position, volumes and all valid flags and loads the
// register defaults; the sample store is not cleared. A stalled output holds
// the sequencer in its last step while the queue takes transactions until full.
module ramped_resampling_mixer_unit
#(
    parameter int STORE_DEPTH = rrm_pkg::DEFAULT_STORE_DEPTH,
    parameter int FRAC_SHIFT  = rrm_pkg::DEFAULT_FRAC_SHIFT
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sample_addr[11:0], sample_value[19:12], dest_left[51:20],
    // dest_right[83:52], zero fill[87:84]
    input  logic [rrm_pkg::S_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [rrm_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mixed_left[31:0], mixed_right[63:32]
    output logic [rrm_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           cfg_we,
    input  logic [rrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    rrm_pkg::cfg_t   cfg_reg;
    rrm_pkg::cfg_t   cfg_next;
    logic            push_valid;
    logic            push_ready;
    rrm_pkg::entry_t push_data;
    logic            pop_valid;
    logic            pop_ready;
    rrm_pkg::entry_t pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rrm_pkg::REG_STEP_INCREMENT:
                    cfg_next.step_increment = cfg_wdata[rrm_pkg::POS_W-1:0];
                rrm_pkg::REG_START_POSITION:
                    cfg_next.start_position = cfg_wdata[rrm_pkg::POS_W-1:0];
                rrm_pkg::REG_LEFT_VOLUME_START:
                    cfg_next.left_volume_start = cfg_wdata[rrm_pkg::VOL_W-1:0];
                rrm_pkg::REG_RIGHT_VOLUME_START:
                    cfg_next.right_volume_start = cfg_wdata[rrm_pkg::VOL_W-1:0];
                rrm_pkg::REG_LEFT_RAMP:
                    cfg_next.left_ramp = cfg_wdata[rrm_pkg::VOL_W-1:0];
                rrm_pkg::REG_RIGHT_RAMP:
                    cfg_next.right_ramp = cfg_wdata[rrm_pkg::VOL_W-1:0];
                rrm_pkg::REG_CHANNEL_MODE:
                    cfg_next.channel_mode = cfg_wdata[rrm_pkg::MODE_W-1:0];
                rrm_pkg::REG_INTERPOLATE:
                    cfg_next.interpolate = cfg_wdata[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_increment     <= rrm_pkg::STEP_RESET;
            cfg_reg.start_position     <= '0;
            cfg_reg.left_volume_start  <= '0;
            cfg_reg.right_volume_start <= '0;
            cfg_reg.left_ramp          <= '0;
            cfg_reg.right_ramp         <= '0;
            cfg_reg.channel_mode       <= rrm_pkg::MODE_STEREO;
            cfg_reg.interpolate        <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rrm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rrm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rrm_back
    #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAC_SHIFT  (FRAC_SHIFT)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (pop_valid),
        .q_ready  (pop_ready),
        .q_data   (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
